[src/chq_pkg.sv]
// Package for the quaternion Hermite interpolation and normalize unit.
// Holds fixed widths and constants used by all modules; no dependencies.
package chq_pkg;
  localparam int unsigned LANES     = 4;
  localparam int unsigned T_BITS    = 17;
  localparam int unsigned DT_BITS   = 16;
  localparam int unsigned W_BITS    = 19;
  localparam int unsigned MAG_BITS  = 30;
  localparam int unsigned SQ_BITS   = 62;
  localparam int unsigned ROOT_BITS = 31;
  localparam logic [T_BITS-1:0] T_ONE = 17'd65536;
  typedef logic signed [W_BITS-1:0] weight_t;
endpackage

[src/chq_weights.sv]
// Three-stage pipeline forming t^2, t^3 and the four Hermite basis weights.
// Depends on chq_pkg.
module chq_weights import chq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [T_BITS-1:0] position_i,
  output logic              valid_o,
  output weight_t           h00_o,
  output weight_t           h10_o,
  output weight_t           h01_o,
  output weight_t           h11_o
);
  logic [2:0] v_q;
  logic [T_BITS-1:0] t1_q, t2_q, t1b_q, t2b_q, t3_q;
  logic [T_BITS-1:0] tc, t2_d, t3_d;
  logic [2*T_BITS-1:0] sq, cu;
  logic signed [W_BITS:0] st, s2, s3, a00, a10, a01, a11;

  always_comb begin
    tc   = (position_i > T_ONE) ? T_ONE : position_i;
    sq   = 34'(tc) * 34'(tc) + 34'd32768;
    t2_d = sq[32:16];
    cu   = 34'(t2_q) * 34'(t1_q) + 34'd32768;
    t3_d = cu[32:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= tc;
    t2_q  <= t2_d;
    t1b_q <= t1_q;
    t2b_q <= t2_q;
    t3_q  <= t3_d;
  end

  always_comb begin
    st  = $signed({3'b0, t1b_q});
    s2  = $signed({3'b0, t2b_q});
    s3  = $signed({3'b0, t3_q});
    a00 = 20'sd2 * s3 - 20'sd3 * s2 + 20'sd65536;
    a10 = s3 - 20'sd2 * s2 + st;
    a01 = 20'sd3 * s2 - 20'sd2 * s3;
    a11 = s3 - s2;
  end

  always_ff @(posedge clk_i) begin
    h00_o <= a00[W_BITS-1:0];
    h10_o <= a10[W_BITS-1:0];
    h01_o <= a01[W_BITS-1:0];
    h11_o <= a11[W_BITS-1:0];
  end

  assign valid_o = v_q[2];
endmodule

[src/chq_isqrt.sv]
// Fully pipelined integer square root, one result bit per stage.
// Carries a side payload alongside. Depends on chq_pkg.
module chq_isqrt import chq_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [SQ_BITS-1:0]   radicand_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [ROOT_BITS-1:0] root_o,
  output logic [SIDE_W-1:0]    side_o
);
  localparam int unsigned STEPS = ROOT_BITS;

  logic [STEPS-1:0]   v_q;
  logic [SQ_BITS-1:0] n_q    [STEPS];
  logic [SQ_BITS-1:0] r_q    [STEPS];
  logic [SIDE_W-1:0]  side_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * i);
    logic [SQ_BITS-1:0] n_in, r_in, n_d, r_d, tr;
    logic [SIDE_W-1:0]  s_in;
    logic               v_in;

    if (i == 0) begin : g_first
      assign n_in = radicand_i;
      assign r_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign n_in = n_q[i-1];
      assign r_in = r_q[i-1];
      assign s_in = side_q[i-1];
      assign v_in = v_q[i-1];
    end

    always_comb begin
      tr = r_in + BIT;
      if (n_in >= tr) begin
        n_d = n_in - tr;
        r_d = (r_in >> 1) + BIT;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[i]    <= n_d;
      r_q[i]    <= r_d;
      side_q[i] <= s_in;
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign root_o  = r_q[STEPS-1][ROOT_BITS-1:0];
  assign side_o  = side_q[STEPS-1];
endmodule

[src/chq_divide.sv]
// Pipelined restoring divider for all lanes: normalized magnitude over the root,
// one quotient bit per stage. Depends on chq_pkg.
module chq_divide import chq_pkg::*; #(
  parameter int unsigned LANE_BITS = 16,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [LANES-1:0][MAG_BITS-1:0]      mag_i,
  input  logic [ROOT_BITS-1:0]                divisor_i,
  input  logic [SIDE_W-1:0]                   side_i,
  output logic                                valid_o,
  output logic [LANES-1:0][LANE_BITS:0]       quot_o,
  output logic [SIDE_W-1:0]                   side_o
);
  localparam int unsigned QB = LANE_BITS + 1;

  logic [QB-1:0]                          v_q;
  logic [ROOT_BITS-1:0]                   div_q  [QB];
  logic [SIDE_W-1:0]                      side_q [QB];
  logic [LANES-1:0][ROOT_BITS-1:0]        rem_q  [QB];
  logic [LANES-1:0][QB-1:0]               lo_q   [QB];
  logic [LANES-1:0][QB-1:0]               quo_q  [QB];

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic                            v_in;
    logic [ROOT_BITS-1:0]            d_in;
    logic [SIDE_W-1:0]               s_in;
    logic [LANES-1:0][ROOT_BITS-1:0] rem_in, rem_d;
    logic [LANES-1:0][QB-1:0]        lo_in, lo_d, quo_in, quo_d;

    if (j == 0) begin : g_first
      assign v_in = valid_i;
      assign d_in = divisor_i;
      assign s_in = side_i;
      for (genvar k = 0; k < LANES; k++) begin : g_init
        assign rem_in[k] = ROOT_BITS'(mag_i[k][MAG_BITS-1:2]);
        assign lo_in[k]  = {mag_i[k][1:0], {(QB-2){1'b0}}};
        assign quo_in[k] = '0;
      end
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign d_in   = div_q[j-1];
      assign s_in   = side_q[j-1];
      assign rem_in = rem_q[j-1];
      assign lo_in  = lo_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      logic [ROOT_BITS:0] r2;
      logic               ge;
      for (int k = 0; k < LANES; k++) begin
        r2 = {rem_in[k], lo_in[k][QB-1]};
        ge = r2 >= {1'b0, d_in};
        rem_d[k] = ge ? ROOT_BITS'(r2 - {1'b0, d_in}) : r2[ROOT_BITS-1:0];
        lo_d[k]  = lo_in[k] << 1;
        quo_d[k] = {quo_in[k][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[j]  <= d_in;
      side_q[j] <= s_in;
      rem_q[j]  <= rem_d;
      lo_q[j]   <= lo_d;
      quo_q[j]  <= quo_d;
    end
  end

  assign valid_o = v_q[QB-1];
  assign quot_o  = quo_q[QB-1];
  assign side_o  = side_q[QB-1];
endmodule

[src/cubic_hermite_quat_normalize_unit.sv]
// Cubic Hermite quaternion interpolation with normalization to unit length.
// The path from start to done_o includes the 31-stage square root and the
// LANE_BITS+1 stage divider pipelines.
// Throughput: one item per cycle; busy is always low and results cannot be stalled.
// Reset clears all valid bits; data registers are not reset. Depends on chq_pkg.
module cubic_hermite_quat_normalize_unit import chq_pkg::*; #(
  parameter int unsigned LANE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [63:0]   start_quat_i,
  input  logic [63:0]   out_tangent_i,
  input  logic [63:0]   end_quat_i,
  input  logic [63:0]   in_tangent_i,
  input  logic [16:0]   position_i,
  input  logic [15:0]   interval_i,
  output logic          done_o,
  output logic [63:0]   result_quat_o,
  output logic          zero_length_o
);
  localparam int unsigned L     = LANE_BITS;
  localparam int unsigned TW    = L + 13;
  localparam int unsigned PW    = TW + W_BITS;
  localparam int unsigned SW    = PW + 2;
  localparam int unsigned BW    = $clog2(SW + 1);
  localparam int unsigned SIDE1 = LANES + 1 + LANES * MAG_BITS;
  localparam int unsigned SIDE2 = LANES + 1;
  localparam logic [L:0]  HALF  = (L + 1)'(1) << (L - 1);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start;

  // stage A (plus two delay stages to line up with the weights)
  logic signed [L-1:0]  p0_q [3][LANES];
  logic signed [L-1:0]  p1_q [3][LANES];
  logic signed [TW-1:0] m0_q [3][LANES];
  logic signed [TW-1:0] m1_q [3][LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_in
    logic signed [L-1:0]  a0, a1, b0, b1;
    logic signed [L+16:0] s0, s1;
    if ((k + 1) * L <= 64) begin : g_fit
      assign a0 = start_quat_i[k*L +: L];
      assign a1 = end_quat_i[k*L +: L];
      assign b0 = out_tangent_i[k*L +: L];
      assign b1 = in_tangent_i[k*L +: L];
    end else begin : g_nofit
      assign a0 = '0;
      assign a1 = '0;
      assign b0 = '0;
      assign b1 = '0;
    end
    assign s0 = b0 * $signed({1'b0, interval_i});
    assign s1 = b1 * $signed({1'b0, interval_i});

    always_ff @(posedge clk_i) begin
      p0_q[0][k] <= a0;
      p1_q[0][k] <= a1;
      m0_q[0][k] <= s0[L+16:4];
      m1_q[0][k] <= s1[L+16:4];
      for (int d = 1; d < 3; d++) begin
        p0_q[d][k] <= p0_q[d-1][k];
        p1_q[d][k] <= p1_q[d-1][k];
        m0_q[d][k] <= m0_q[d-1][k];
        m1_q[d][k] <= m1_q[d-1][k];
      end
    end
  end

  logic    vw;
  weight_t h00, h10, h01, h11;

  chq_weights u_weights (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .position_i (position_i),
    .valid_o    (vw),
    .h00_o      (h00),
    .h10_o      (h10),
    .h01_o      (h01),
    .h11_o      (h11)
  );

  // D: products, E: sums, F: magnitudes, G: max and bit length, H: shift,
  // I: squares, J: sum of squares
  logic vd_q, ve_q, vf_q, vg_q, vh_q, vi_q, vj_q;
  logic signed [PW-1:0] pr_q [LANES][4];
  logic signed [SW-1:0] s_q  [LANES];
  logic [SW-1:0]        mag_q [LANES];
  logic [SW-1:0]        magg_q [LANES];
  logic [MAG_BITS-1:0]  nm_q [LANES];
  logic [MAG_BITS-1:0]  nmi_q [LANES];
  logic [MAG_BITS-1:0]  nmj_q [LANES];
  logic [2*MAG_BITS-1:0] sq_q [LANES];
  logic [SQ_BITS-1:0]   sum_q;
  logic [LANES-1:0]     negf_q, negg_q, negh_q, negi_q, negj_q;
  logic                 zg_q, zh_q, zi_q, zj_q;
  logic [BW-1:0]        b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
    end else begin
      vd_q <= vw;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vh_q;
      vj_q <= vi_q;
    end
  end

  logic [SW-1:0] maxm;
  logic [BW-1:0] blen;

  always_comb begin
    maxm = '0;
    for (int k = 0; k < LANES; k++) begin
      if (mag_q[k] > maxm) maxm = mag_q[k];
    end
    blen = '0;
    for (int i = 0; i < SW; i++) begin
      if (maxm[i]) blen = BW'(i + 1);
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic signed [PW-1:0] x0, x1, x2, x3;
    logic [SW-1:0]        sh;
    assign x0 = p0_q[2][k] * h00;
    assign x1 = m0_q[2][k] * h10;
    assign x2 = p1_q[2][k] * h01;
    assign x3 = m1_q[2][k] * h11;

    always_comb begin
      if (b_q > BW'(MAG_BITS)) begin
        sh = magg_q[k] >> (b_q - BW'(MAG_BITS));
      end else begin
        sh = magg_q[k] << (BW'(MAG_BITS) - b_q);
      end
    end

    always_ff @(posedge clk_i) begin
      pr_q[k][0] <= x0;
      pr_q[k][1] <= x1;
      pr_q[k][2] <= x2;
      pr_q[k][3] <= x3;
      s_q[k]     <= SW'(pr_q[k][0]) + SW'(pr_q[k][1]) + SW'(pr_q[k][2])
                    + SW'(pr_q[k][3]);
      mag_q[k]   <= s_q[k][SW-1] ? SW'(-s_q[k]) : SW'(s_q[k]);
      negf_q[k]  <= s_q[k][SW-1];
      magg_q[k]  <= mag_q[k];
      nm_q[k]    <= sh[MAG_BITS-1:0];
      nmi_q[k]   <= nm_q[k];
      sq_q[k]    <= (2*MAG_BITS)'(nm_q[k]) * (2*MAG_BITS)'(nm_q[k]);
      nmj_q[k]   <= nmi_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    b_q    <= blen;
    zg_q   <= (maxm == '0);
    negg_q <= negf_q;
    zh_q   <= zg_q;
    negh_q <= negg_q;
    zi_q   <= zh_q;
    negi_q <= negh_q;
    zj_q   <= zi_q;
    negj_q <= negi_q;
    sum_q  <= SQ_BITS'(sq_q[0]) + SQ_BITS'(sq_q[1]) + SQ_BITS'(sq_q[2])
              + SQ_BITS'(sq_q[3]);
  end

  logic [SIDE1-1:0] side1_in, side1_out;
  logic             vr;
  logic [ROOT_BITS-1:0] root;

  always_comb begin
    side1_in = '0;
    side1_in[LANES-1:0] = negj_q;
    side1_in[LANES]     = zj_q;
    for (int k = 0; k < LANES; k++) begin
      side1_in[LANES + 1 + k*MAG_BITS +: MAG_BITS] = nmj_q[k];
    end
  end

  chq_isqrt #(.SIDE_W(SIDE1)) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vj_q),
    .radicand_i (sum_q),
    .side_i     (side1_in),
    .valid_o    (vr),
    .root_o     (root),
    .side_o     (side1_out)
  );

  logic [LANES-1:0][MAG_BITS-1:0] dmag;
  for (genvar k = 0; k < LANES; k++) begin : g_dmag
    assign dmag[k] = side1_out[LANES + 1 + k*MAG_BITS +: MAG_BITS];
  end

  logic                        vq;
  logic [LANES-1:0][L:0]       quot;
  logic [SIDE2-1:0]            side2_out;

  chq_divide #(.LANE_BITS(L), .SIDE_W(SIDE2)) u_divide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vr),
    .mag_i     (dmag),
    .divisor_i (root),
    .side_i    (side1_out[SIDE2-1:0]),
    .valid_o   (vq),
    .quot_o    (quot),
    .side_o    (side2_out)
  );

  logic [63:0] res_d;

  always_comb begin
    logic [L+1:0] rq;
    logic [L:0]   qc;
    logic [L-1:0] val;
    res_d = '0;
    for (int k = 0; k < LANES; k++) begin
      rq = (L + 2)'(quot[k]) + (L + 2)'(1);
      qc = rq[L+1:1];
      if (qc > HALF) qc = HALF;
      if (side2_out[k]) begin
        val = L'(-qc);
      end else if (qc >= HALF) begin
        val = L'(HALF - (L + 1)'(1));
      end else begin
        val = qc[L-1:0];
      end
      if ((k + 1) * L <= 64 && !side2_out[LANES]) begin
        res_d[k*L +: L] = val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vq;
    end
  end

  always_ff @(posedge clk_i) begin
    result_quat_o <= res_d;
    zero_length_o <= side2_out[LANES];
  end
endmodule
